@@ src/astfr_pkg.sv @@
// Package for the serial audio transmit FIFO register block.
// Holds the operation codes, register word indices, bit positions and
// the control/status write helper. No dependencies.
package astfr_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PULL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Register word indices (byte offset divided by four).
  localparam logic [7:0] W_VERID = 8'h00;
  localparam logic [7:0] W_PARAM = 8'h01;
  localparam logic [7:0] W_TCSR  = 8'h02;
  localparam logic [7:0] W_TCR1  = 8'h03;
  localparam logic [7:0] W_TCR2  = 8'h04;
  localparam logic [7:0] W_TCR5  = 8'h07;
  localparam logic [7:0] W_TDR0  = 8'h08;
  localparam logic [7:0] W_TDR1  = 8'h09;
  localparam logic [7:0] W_TFR0  = 8'h10;
  localparam logic [7:0] W_TFR1  = 8'h11;
  localparam logic [7:0] W_RCSR  = 8'h22;
  localparam logic [7:0] W_RDR0  = 8'h28;
  localparam logic [7:0] W_RDR1  = 8'h29;
  localparam logic [7:0] W_RFR0  = 8'h30;
  localparam logic [7:0] W_RFR1  = 8'h31;

  // Fixed register contents.
  localparam logic [31:0] VERID_WORD  = 32'h0301_0000;
  localparam logic [31:0] PARAM_RESET = 32'h0005_0402;

  // Control/status bit positions.
  localparam int unsigned B_TE   = 31;
  localparam int unsigned B_FR   = 25;
  localparam int unsigned B_SR   = 24;
  localparam int unsigned B_FEF  = 18;
  localparam int unsigned B_FWF  = 17;
  localparam int unsigned B_FRF  = 16;
  localparam int unsigned B_FWDE = 1;
  localparam int unsigned B_FRDE = 0;
  localparam int unsigned B_BCM  = 24;

  localparam logic [31:0] STICKY_MASK = 32'h001C_0000;
  localparam logic [31:0] MOMENT_MASK = 32'h0300_0000;
  localparam logic [4:0]  WIDTH_16    = 5'd15;

  // Control/status write: ones clear the sticky flags, other bits take the
  // written value, and the momentary reset bits never stay set.
  function automatic logic [31:0] csr_write(input logic [31:0] cur,
                                            input logic [31:0] val);
    logic [31:0] kept;
    kept = cur & ~(val & STICKY_MASK);
    return ((kept & STICKY_MASK) | (val & ~STICKY_MASK)) & ~MOMENT_MASK;
  endfunction

  // True for words that are plain storage (not decoded specially).
  function automatic logic is_plain_word(input logic [7:0] word);
    logic res;
    unique case (word) inside
      W_VERID, W_PARAM, W_TCSR, W_TCR1, W_TCR2, W_TCR5, W_TDR0, W_TDR1,
      W_TFR0, W_TFR1, W_RCSR, W_RDR0, W_RDR1, W_RFR0, W_RFR1: res = 1'b0;
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

@@ src/astfr_if.sv @@
// Channel interfaces of the serial audio transmit FIFO register block.
// Request words carry bus accesses and serializer pulls; response words
// carry the result of each request. No dependencies.
interface astfr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  address;
  logic [31:0] write_data;

  modport source(output valid, operation, address, write_data, input ready);
  modport sink(input valid, operation, address, write_data, output ready);
endinterface

interface astfr_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        read_data;
  logic               sample_valid;
  logic signed [15:0] sample_out;
  logic               irq;
  logic               dma_tx_request;

  modport source(output valid, read_data, sample_valid, sample_out, irq,
                 dma_tx_request, input ready);
  modport sink(input valid, read_data, sample_valid, sample_out, irq,
               dma_tx_request, output ready);
endinterface

@@ src/astfr_plain_store.sv @@
// Plain storage words of the register file, one write or read per word.
// Each word has a valid bit cleared by reset, so unwritten words read zero.
// Depends on nothing but its parameter.
module astfr_plain_store #(
  parameter int REGISTER_WORDS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic                              we,
  input  logic [$clog2(REGISTER_WORDS)-1:0] idx,
  input  logic [31:0]                       wdata,
  output logic [31:0]                       rdata
);

  logic [31:0]               mem [REGISTER_WORDS];
  logic [REGISTER_WORDS-1:0] vld_r;
  logic [31:0]               rdata_r;
  logic                      rvld_r;

  // Storage array with registered read data.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (we) begin
        mem[idx] <= wdata;
      end
      rdata_r <= mem[idx];
    end
  end

  // Written-word flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else if (acc) begin
      if (we) begin
        vld_r[idx] <= 1'b1;
      end
      rvld_r <= vld_r[idx];
    end
  end

  assign rdata = rvld_r ? rdata_r : 32'd0;

endmodule

@@ src/astfr_tx_store.sv @@
// Transmit FIFO word storage with a prefetched head register.
// The head always holds the entry at the next read index, written through
// when a push lands on that entry. Depends on nothing but its parameter.
module astfr_tx_store #(
  parameter int FIFO_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          push,
  input  logic [$clog2(FIFO_SLOTS)-1:0] wr_idx,
  input  logic [31:0]                   wdata,
  input  logic [$clog2(FIFO_SLOTS)-1:0] rd_idx_nxt,
  output logic [31:0]                   head
);

  logic [31:0] mem [FIFO_SLOTS];
  logic [31:0] head_r;

  // Write port and registered head read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (push) begin
        mem[wr_idx] <= wdata;
      end
      if (push && (wr_idx == rd_idx_nxt)) begin
        head_r <= wdata;
      end else begin
        head_r <= mem[rd_idx_nxt];
      end
    end
  end

  assign head = head_r;

endmodule

@@ src/audio_serial_tx_fifo_regs.sv @@
// Serial audio transmit register block: top level with the request and
// result stages. Uses astfr_pkg, astfr_if, astfr_plain_store, astfr_tx_store.
//
// The block takes one request word per clock cycle, back to back, while the
// response side takes its response words: a first stage registers the
// request and reads the plain register storage, and a second stage applies
// the access to the control registers and the transmit FIFO and registers
// the response. Requests keep flowing while a response waits, up to the one
// request held in the first stage. Control registers, FIFO pointers and the
// FIFO head register live in flip-flops; plain storage words are a memory
// with one valid bit per word, so no clearing pass runs after reset. The
// parameter word is written through the cfg port; the user must write it
// only while the block is idle, as the block itself does not enforce it.
module audio_serial_tx_fifo_regs #(
  parameter int FIFO_SLOTS     = 32,
  parameter int REGISTER_WORDS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  astfr_req_if.sink          in_ch,
  astfr_rsp_if.source        out_ch
);

  import astfr_pkg::*;

  localparam int IW = $clog2(FIFO_SLOTS);
  localparam int LW = $clog2(FIFO_SLOTS + 1);
  localparam int AW = $clog2(REGISTER_WORDS);

  // Stage one: registered request.
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [7:0]  s1_word_r;
  logic [31:0] s1_data_r;

  // Control registers and FIFO state.
  logic [31:0]   param_r;
  logic [31:0]   tcsr_r, tcsr_nxt;
  logic [31:0]   tcr1_r, tcr1_nxt;
  logic [31:0]   tcr2_r, tcr2_nxt;
  logic [31:0]   tcr5_r, tcr5_nxt;
  logic [31:0]   rcsr_r, rcsr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt;

  // Result register.
  logic               out_valid_r;
  logic [31:0]        read_data_r, read_data_nxt;
  logic               sample_valid_r, sample_valid_nxt;
  logic signed [15:0] sample_out_r, sample_out_nxt;
  logic               irq_r, irq_nxt;
  logic               dma_r, dma_nxt;

  logic        in_acc;
  logic        s2_adv;
  op_t         in_op;
  logic [7:0]  in_word;
  logic        in_block_in;
  logic        plain_we;
  logic [31:0] plain_rdata;
  logic [31:0] head;
  logic        push;

  logic        s1_in_block;
  logic [16:0] depth_pow;
  logic [16:0] depth;
  logic        full;
  logic [7:0]  level_ext;
  logic        te_nxt;
  logic        frf_nxt;
  logic        fwf_nxt;
  logic [4:0]  tflags;
  logic [31:0] tcsr_rd;

  // Handshake: the second stage moves when the result register is free.
  assign s2_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s2_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Request decode for the plain storage port.
  assign in_op       = op_t'(in_ch.operation);
  assign in_word     = in_ch.address[9:2];
  assign in_block_in = ({1'b0, in_word} < 9'(REGISTER_WORDS));
  assign plain_we    = (in_op == OP_WRITE) && in_block_in && is_plain_word(in_word);

  astfr_plain_store #(
    .REGISTER_WORDS(REGISTER_WORDS)
  ) u_plain (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .we    (plain_we),
    .idx   (in_ch.address[AW+1:2]),
    .wdata (in_ch.write_data),
    .rdata (plain_rdata)
  );

  astfr_tx_store #(
    .FIFO_SLOTS(FIFO_SLOTS)
  ) u_txs (
    .clk        (clk),
    .en         (s2_adv),
    .push       (push),
    .wr_idx     (wr_idx_r),
    .wdata      (s1_data_r),
    .rd_idx_nxt (rd_idx_nxt),
    .head       (head)
  );

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_word_r <= in_word;
      s1_data_r <= in_ch.write_data;
    end
  end

  // Usable FIFO depth from the parameter word, clamped to the slot count.
  assign depth_pow   = 17'd1 << param_r[11:8];
  assign depth       = (depth_pow > 17'(FIFO_SLOTS)) ? 17'(FIFO_SLOTS) : depth_pow;
  assign full        = (17'(level_r) >= depth);
  assign s1_in_block = ({1'b0, s1_word_r} < 9'(REGISTER_WORDS));

  // Live transmit status as seen by a read of the control/status word.
  always_comb begin
    tcsr_rd = tcsr_r & ~(MOMENT_MASK | (32'd1 << B_FRF) | (32'd1 << B_FWF));
    if (tcsr_r[B_TE]) begin
      tcsr_rd[B_FRF] = (8'(level_r) <= 8'(tcr1_r[4:0]));
      tcsr_rd[B_FWF] = (level_r == '0);
    end
  end

  // Stage two: apply the request to the registers and the FIFO.
  always_comb begin
    tcsr_nxt         = tcsr_r;
    tcr1_nxt         = tcr1_r;
    tcr2_nxt         = tcr2_r;
    tcr5_nxt         = tcr5_r;
    rcsr_nxt         = rcsr_r;
    level_nxt        = level_r;
    rd_idx_nxt       = rd_idx_r;
    wr_idx_nxt       = wr_idx_r;
    push             = 1'b0;
    read_data_nxt    = 32'd0;
    sample_valid_nxt = 1'b0;
    sample_out_nxt   = '0;
    if (s2_adv) begin
      case (s1_op_r)
        OP_READ: begin
          if (s1_in_block) begin
            unique case (s1_word_r) inside
              W_VERID: read_data_nxt = VERID_WORD;
              W_PARAM: read_data_nxt = param_r;
              W_TCSR:  read_data_nxt = tcsr_rd;
              W_TCR1:  read_data_nxt = tcr1_r;
              W_TCR2:  read_data_nxt = tcr2_r;
              W_TCR5:  read_data_nxt = tcr5_r;
              W_RCSR:  read_data_nxt = rcsr_r & ~(MOMENT_MASK | (32'd1 << B_FRF) |
                                        (32'd1 << B_FWF) | (32'd1 << B_FEF));
              W_TFR0, W_TFR1: read_data_nxt = {10'd0, 6'(wr_idx_r), 10'd0, 6'(rd_idx_r)};
              W_RDR0, W_RDR1, W_RFR0, W_RFR1: read_data_nxt = 32'd0;
              default: read_data_nxt = plain_rdata;
            endcase
          end
        end
        OP_WRITE: begin
          if (s1_in_block) begin
            unique case (s1_word_r) inside
              W_TCSR: begin
                if (s1_data_r[B_FR]) begin
                  level_nxt  = '0;
                  rd_idx_nxt = '0;
                  wr_idx_nxt = '0;
                end
                tcsr_nxt = csr_write(tcsr_r, s1_data_r);
              end
              W_RCSR: rcsr_nxt = csr_write(rcsr_r, s1_data_r);
              W_TCR1: tcr1_nxt = s1_data_r;
              W_TCR2: tcr2_nxt = s1_data_r;
              W_TCR5: tcr5_nxt = s1_data_r;
              W_TDR0, W_TDR1: begin
                if (full) begin
                  tcsr_nxt[B_FEF] = 1'b1;
                end else begin
                  push       = 1'b1;
                  wr_idx_nxt = (wr_idx_r == IW'(FIFO_SLOTS - 1)) ? '0 : wr_idx_r + 1'b1;
                  level_nxt  = level_r + 1'b1;
                end
              end
              default: begin
                // Read-only and plain words: nothing held here changes.
              end
            endcase
          end
        end
        OP_PULL: begin
          if (tcsr_r[B_TE] && tcr2_r[B_BCM] && (tcr5_r[20:16] == WIDTH_16) &&
              (level_r != '0)) begin
            sample_valid_nxt = 1'b1;
            sample_out_nxt   = head[15:0];
            rd_idx_nxt       = (rd_idx_r == IW'(FIFO_SLOTS - 1)) ? '0 : rd_idx_r + 1'b1;
            level_nxt        = level_r - 1'b1;
          end
        end
        default: begin
          // No effect.
        end
      endcase
    end
  end

  // Interrupt and DMA request from the state after the request.
  assign level_ext = 8'(level_nxt);
  assign te_nxt    = tcsr_nxt[B_TE];
  assign frf_nxt   = te_nxt && (level_ext <= 8'(tcr1_nxt[4:0]));
  assign fwf_nxt   = te_nxt && (level_nxt == '0);
  assign tflags    = {tcsr_nxt[20:18], fwf_nxt, frf_nxt};
  assign irq_nxt   = (|(tflags & tcsr_nxt[12:8])) || (|(rcsr_nxt[20:18] & rcsr_nxt[12:10]));
  assign dma_nxt   = te_nxt && ((tcsr_nxt[B_FRDE] && frf_nxt) ||
                                (tcsr_nxt[B_FWDE] && (level_nxt == '0)));

  // Parameter word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_r <= PARAM_RESET;
    end else if (cfg_we) begin
      param_r <= cfg_wdata;
    end
  end

  // Control registers and FIFO pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcsr_r   <= '0;
      tcr1_r   <= '0;
      tcr2_r   <= '0;
      tcr5_r   <= '0;
      rcsr_r   <= '0;
      level_r  <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
    end else if (s2_adv) begin
      tcsr_r   <= tcsr_nxt;
      tcr1_r   <= tcr1_nxt;
      tcr2_r   <= tcr2_nxt;
      tcr5_r   <= tcr5_nxt;
      rcsr_r   <= rcsr_nxt;
      level_r  <= level_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      read_data_r    <= read_data_nxt;
      sample_valid_r <= sample_valid_nxt;
      sample_out_r   <= sample_out_nxt;
      irq_r          <= irq_nxt;
      dma_r          <= dma_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_data      = read_data_r;
  assign out_ch.sample_valid   = sample_valid_r;
  assign out_ch.sample_out     = sample_out_r;
  assign out_ch.irq            = irq_r;
  assign out_ch.dma_tx_request = dma_r;

endmodule

@@ tb/sai_tx_check_pkg.sv @@
// Scoreboard for the serial audio transmit FIFO register block testbench.
// Predicts the response word of every accepted request word and checks the
// block's responses against it. Depends on astfr_pkg.
package sai_tx_check_pkg;
  import astfr_pkg::*;

  // One response word as the block hands it over.
  typedef struct packed {
    logic [31:0] read_data;
    logic        sample_valid;
    logic [15:0] sample_out;
    logic        irq;
    logic        dma_tx_request;
  } sai_reply_t;

  class sai_tx_scoreboard;
    logic [31:0] regs [128];
    logic [31:0] tx_words [32];
    logic [5:0]  fill_level;
    logic [4:0]  head_ptr;
    logic [4:0]  tail_ptr;
    logic [31:0] param_word;
    int          errors;
    sai_reply_t  owed_responses[$];

    function new();
      foreach (regs[i]) regs[i] = '0;
      fill_level = '0;
      head_ptr   = '0;
      tail_ptr   = '0;
      param_word = PARAM_RESET;
      errors     = 0;
    endfunction

    function int pending();
      return owed_responses.size();
    endfunction

    // A one in a sticky flag clears it, the other bits take the new value,
    // and the momentary reset bits never stay set.
    function logic [31:0] merged_csr(logic [31:0] cur, logic [31:0] val);
      logic [31:0] res;
      res = ((cur & ~val) & STICKY_MASK) | (val & ~STICKY_MASK);
      return res & ~MOMENT_MASK;
    endfunction

    // Apply one accepted request word to the shadow state and queue the
    // response word it must produce.
    function void note_request(op_t op, logic [9:0] addr, logic [31:0] wdata);
      sai_reply_t  r;
      logic [7:0]  word;
      logic [31:0] v;
      logic [31:0] tcsr;
      logic [31:0] rcsr;
      logic [31:0] tflags;
      logic [31:0] rflags;
      logic [4:0]  wm;
      int          depth;
      word = addr[9:2];
      wm   = regs[W_TCR1][4:0];
      r    = '0;
      case (op)
        OP_READ: if (!addr[9]) begin
          v = regs[word[6:0]];
          case (word)
            W_VERID: v = VERID_WORD;
            W_PARAM: v = param_word;
            W_TCSR: begin
              v[B_SR]  = 1'b0;
              v[B_FR]  = 1'b0;
              v[B_FRF] = 1'b0;
              v[B_FWF] = 1'b0;
              // The FIFO flags are live only while the transmitter is on.
              if (v[B_TE]) begin
                v[B_FRF] = (fill_level <= wm);
                v[B_FWF] = (fill_level == 0);
              end
            end
            W_RCSR: begin
              v[B_SR]  = 1'b0;
              v[B_FR]  = 1'b0;
              v[B_FRF] = 1'b0;
              v[B_FWF] = 1'b0;
              v[B_FEF] = 1'b0;
            end
            W_TFR0, W_TFR1: v = {11'b0, tail_ptr, 11'b0, head_ptr};
            W_RDR0, W_RDR1, W_RFR0, W_RFR1: v = '0;
            default: ;
          endcase
          r.read_data = v;
        end
        OP_WRITE: if (!addr[9]) begin
          case (word)
            W_VERID, W_PARAM, W_TFR0, W_TFR1, W_RDR0, W_RDR1, W_RFR0, W_RFR1: ;
            W_TCSR: begin
              if (wdata[B_FR]) begin
                fill_level = '0;
                head_ptr   = '0;
                tail_ptr   = '0;
              end
              regs[W_TCSR] = merged_csr(regs[W_TCSR], wdata);
            end
            W_RCSR: regs[W_RCSR] = merged_csr(regs[W_RCSR], wdata);
            W_TDR0, W_TDR1: begin
              // Usable depth comes from the parameter word, capped at the store size.
              depth = (param_word[11:8] >= 5) ? 32 : (1 << param_word[11:8]);
              if (fill_level >= depth) begin
                regs[W_TCSR][B_FEF] = 1'b1;
              end else begin
                tx_words[tail_ptr] = wdata;
                tail_ptr++;
                fill_level++;
              end
            end
            default: regs[word[6:0]] = wdata;
          endcase
        end
        OP_PULL: begin
          if (regs[W_TCSR][B_TE] && regs[W_TCR2][B_BCM] &&
              regs[W_TCR5][20:16] == WIDTH_16 && fill_level != 0) begin
            r.sample_valid = 1'b1;
            r.sample_out   = tx_words[head_ptr][15:0];
            head_ptr++;
            fill_level--;
          end
        end
        default: ;
      endcase

      // Interrupt and DMA request follow the state after the request.
      tcsr   = regs[W_TCSR];
      rcsr   = regs[W_RCSR];
      wm     = regs[W_TCR1][4:0];
      tflags = tcsr & STICKY_MASK;
      rflags = rcsr & STICKY_MASK;
      if (tcsr[B_TE]) begin
        tflags[B_FRF] = (fill_level <= wm);
        tflags[B_FWF] = (fill_level == 0);
        r.dma_tx_request = (tcsr[B_FRDE] && fill_level <= wm) ||
                           (tcsr[B_FWDE] && fill_level == 0);
      end
      r.irq = (|(tflags[20:16] & tcsr[12:8])) || (|(rflags[20:16] & rcsr[12:8]));
      owed_responses.push_back(r);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    // Compare one response word with the oldest outstanding prediction.
    function void check_response(sai_reply_t got);
      sai_reply_t want;
      if (owed_responses.size() == 0) begin
        $error("response word arrived with none outstanding");
        errors++;
      end else begin
        want = owed_responses.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("sample_valid", want.sample_valid, got.sample_valid);
        compare_field("sample_out", want.sample_out, got.sample_out);
        compare_field("irq", want.irq, got.irq);
        compare_field("dma_tx_request", want.dma_tx_request, got.dma_tx_request);
      end
    endfunction
  endclass

endpackage

@@ tb/tb_audio_serial_tx_fifo_regs.sv @@
// Top-level testbench for the serial audio transmit FIFO register block.
// Drives directed and random request words, checks every response word.
// Depends on astfr_pkg, astfr_if, sai_tx_check_pkg and the block's RTL.
module tb_audio_serial_tx_fifo_regs;
  timeunit 1ns;
  timeprecision 1ps;
  import astfr_pkg::*;
  import sai_tx_check_pkg::*;

  localparam int         STALL_LIMIT     = 5000;
  localparam int         ITEMS_PER_PHASE = 125;
  localparam logic [7:0] LAST_WORD       = 8'd127;
  localparam logic [9:0] TOP_ADDR        = 10'h3FF;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [31:0]      cfg_wdata;
  logic             calm = 1'b0;
  int               stall_cycles = 0;
  sai_tx_scoreboard sb;

  astfr_req_if req_ch();
  astfr_rsp_if rsp_ch();

  audio_serial_tx_fifo_regs u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: stall at random except during the calm stretch.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // Check every response word the block hands over.
  always @(posedge clk) begin : watch_responses
    sai_reply_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.read_data      = rsp_ch.read_data;
      got.sample_valid   = rsp_ch.sample_valid;
      got.sample_out     = rsp_ch.sample_out;
      got.irq            = rsp_ch.irq;
      got.dma_tx_request = rsp_ch.dma_tx_request;
      sb.check_response(got);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [9:0] reg_addr(input logic [7:0] word);
    return {word, 2'b00};
  endfunction

  // Offer one request word, with random idle cycles ahead of it, and
  // record it once the block has taken it.
  task automatic send_word(input op_t op, input logic [9:0] addr, input logic [31:0] data);
    while (!calm && $urandom_range(0, 99) < 21) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.address    <= addr;
    req_ch.write_data <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, addr, data);
  endtask

  // Stop sending and wait until every predicted response has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write the parameter word; only called while the block is idle.
  task automatic load_param(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.param_word = value;
  endtask

  // Register map corners, FIFO push, overrun and pull, ignored writes.
  task automatic run_directed();
    send_word(OP_READ, reg_addr(W_VERID), 32'h0);
    send_word(OP_READ, reg_addr(W_PARAM), 32'h0);
    wait_idle();
    // A zero parameter word leaves a one-word FIFO, so overrun comes quickly.
    load_param(32'h0);
    send_word(OP_READ, reg_addr(W_PARAM), 32'h0);
    send_word(OP_WRITE, reg_addr(W_TCR2), 32'h0100_0000);
    send_word(OP_WRITE, reg_addr(W_TCR5), 32'h000F_0000);
    send_word(OP_WRITE, reg_addr(W_TCR1), 32'h0);
    send_word(OP_WRITE, reg_addr(W_TCSR), 32'hFFFF_FFFF);
    send_word(OP_READ, reg_addr(W_TCSR), 32'h0);
    send_word(OP_WRITE, reg_addr(W_TDR0), 32'hFFFF_8000);
    send_word(OP_WRITE, reg_addr(W_TDR1), 32'h0000_7FFF);
    send_word(OP_READ, reg_addr(W_TCSR), 32'h0);
    send_word(OP_READ, reg_addr(W_TFR0), 32'h0);
    send_word(OP_READ, reg_addr(W_TFR1) | 10'd3, 32'h0);
    send_word(OP_PULL, 10'h0, 32'h0);
    send_word(OP_PULL, TOP_ADDR, 32'hFFFF_FFFF);
    // Clear the overrun flag while keeping the transmitter on.
    send_word(OP_WRITE, reg_addr(W_TCSR), 32'h8004_1F03);
    send_word(OP_WRITE, reg_addr(W_VERID), 32'hFFFF_FFFF);
    send_word(OP_WRITE, reg_addr(W_PARAM), 32'hFFFF_FFFF);
    send_word(OP_WRITE, TOP_ADDR & ~10'd3, 32'hFFFF_FFFF);
    send_word(OP_READ, TOP_ADDR, 32'h0);
    send_word(OP_WRITE, reg_addr(W_RCSR), 32'hFFFF_FFFF);
    send_word(OP_READ, reg_addr(W_RCSR), 32'h0);
    send_word(OP_WRITE, reg_addr(W_RDR0), 32'hFFFF_FFFF);
    send_word(OP_WRITE, reg_addr(LAST_WORD) | 10'd2, 32'hFFFF_FFFF);
    send_word(OP_READ, reg_addr(LAST_WORD) | 10'd1, 32'h0);
    send_word(OP_NONE, TOP_ADDR, 32'hFFFF_FFFF);
  endtask

  // Mostly well-formed traffic: pushes, pulls and control updates that keep
  // the transmitter running, with a share of random noise.
  task automatic random_traffic(input int count);
    op_t         op;
    logic [9:0]  addr;
    logic [31:0] data;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op   = OP_WRITE;
      addr = 10'($urandom_range(0, 1023));
      data = $urandom();
      if (pick < 30) begin
        addr = {($urandom_range(0, 1) != 0) ? W_TDR1 : W_TDR0, addr[1:0]};
      end else if (pick < 55) begin
        op = OP_PULL;
      end else if (pick < 63) begin
        op = OP_READ;
        case ($urandom_range(0, 2))
          0: addr = {W_TCSR, addr[1:0]};
          1: addr = {W_TFR0, addr[1:0]};
          default: addr = {W_TFR1, addr[1:0]};
        endcase
      end else if (pick < 70) begin
        addr       = {W_TCSR, addr[1:0]};
        data[B_TE] = ($urandom_range(0, 7) != 0);
        data[B_FR] = ($urandom_range(0, 9) == 0);
      end else if (pick < 75) begin
        addr = {W_TCR1, addr[1:0]};
      end else if (pick < 79) begin
        if ($urandom_range(0, 1) != 0) begin
          addr        = {W_TCR2, addr[1:0]};
          data[B_BCM] = ($urandom_range(0, 5) != 0);
        end else begin
          addr = {W_TCR5, addr[1:0]};
          if ($urandom_range(0, 5) != 0) data[20:16] = WIDTH_16;
        end
      end else if (pick < 84) begin
        op   = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
        addr = {W_RCSR, addr[1:0]};
      end else if (pick < 96) begin
        op = op_t'($urandom_range(0, 3));
      end else begin
        op = OP_READ;
      end
      send_word(op, addr, data);
      // Now and then hold off until the block has drained.
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
  endtask

  initial begin
    logic [31:0] phase_params [6];
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_NONE;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Random phases, each under its own parameter word.
    phase_params = '{32'hFFFF_FFFF, 32'h0000_0100, PARAM_RESET, 32'h0000_0200,
                     $urandom(), 32'h0};
    foreach (phase_params[p]) begin
      wait_idle();
      load_param(phase_params[p]);
      calm = (p == 2);
      random_traffic(ITEMS_PER_PHASE);
    end
    calm = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
